### design/pmvu_pkg.sv
// ----------------------------------------------------------------------------
// pmvu_pkg
// shared types and constants for the pde morphology voxel update block
// ----------------------------------------------------------------------------
package pmvu_pkg;

  localparam int unsigned DefValueBits = 16;
  localparam int unsigned NumAxisNb    = 6;
  localparam int unsigned NumDiagNb    = 4;
  localparam int unsigned NumInFields  = 1 + NumAxisNb + NumDiagNb;
  localparam int unsigned DtBits       = 16;
  localparam int unsigned DtFracBits   = 12;
  localparam int unsigned CfgIdxBits   = 3;

  // diagonal interpolation weights, scaled by 2^16
  localparam int unsigned WSide   = 13573;
  localparam int unsigned WCorner = 32768;

  typedef enum logic [CfgIdxBits-1:0] {
    RegSchemeMode   = 3'd0,
    RegDirection    = 3'd1,
    RegTimeStep     = 3'd2,
    RegLimitsEnable = 3'd3,
    RegLowerLimit   = 3'd4,
    RegUpperLimit   = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ModeSum  = 2'd0,
    ModeMax  = 2'd1,
    ModeDiff = 2'd2,
    ModeNone = 2'd3
  } scheme_e;

  typedef struct packed {
    logic    hold;
    logic    dil;
    scheme_e mode;
  } ctrl_t;

endpackage

### design/pmvu_front.sv
// ----------------------------------------------------------------------------
// pmvu_front
// rises, squares and diagonal terms, then squared norm and max-difference norm
// ----------------------------------------------------------------------------
module pmvu_front #(
  parameter int unsigned VALUE_BITS = pmvu_pkg::DefValueBits
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             en_i,
  input  logic                                             valid_i,
  input  logic [pmvu_pkg::NumInFields-1:0][VALUE_BITS-1:0] fields_i,
  input  logic [1:0]                                       scheme_i,
  input  logic                                             dil_i,
  input  logic                                             lim_en_i,
  input  logic [VALUE_BITS-1:0]                            lower_i,
  input  logic [VALUE_BITS-1:0]                            upper_i,
  output logic                                             valid_o,
  output pmvu_pkg::ctrl_t                                  ctrl_o,
  output logic [VALUE_BITS-1:0]                            c_o,
  output logic [2*((VALUE_BITS > 31) ? 31 : VALUE_BITS)+2:0] n2_o,
  output logic [VALUE_BITS+1:0]                            alt_o
);
  import pmvu_pkg::*;

  localparam int unsigned VB  = VALUE_BITS;
  localparam int unsigned QW  = (VB > 31) ? 31 : VB;
  localparam int unsigned N2W = 2 * QW + 3;
  localparam int unsigned NW  = VB + 2;
  localparam int unsigned SW  = VB + 18;

  // stage a
  logic                a_vld_q;
  ctrl_t               a_ctrl_q, a_ctrl_d;
  logic [VB-1:0]       a_c_q;
  logic [VB-1:0]       a_rise_q [NumAxisNb];
  logic [VB-1:0]       a_rise_d [NumAxisNb];
  logic signed [VB+1:0] a_t_q [NumDiagNb];
  logic signed [VB+1:0] a_t_d [NumDiagNb];
  logic signed [VB:0]   a_e_q [NumDiagNb];
  logic signed [VB:0]   a_e_d [NumDiagNb];

  logic signed [VB:0] cx;
  logic signed [VB:0] nx [NumAxisNb];
  logic signed [VB:0] dx [NumDiagNb];
  logic signed [VB:0] df [NumAxisNb];
  logic signed [VB-1:0] c_s, lo_s, up_s;

  always_comb begin
    c_s  = $signed(fields_i[0]);
    lo_s = $signed(lower_i);
    up_s = $signed(upper_i);
    cx   = (VB+1)'(c_s);
    for (int i = 0; i < NumAxisNb; i++) begin
      nx[i] = (VB+1)'($signed(fields_i[1+i]));
      df[i] = dil_i ? (nx[i] - cx) : (cx - nx[i]);
      a_rise_d[i] = (df[i] > 0) ? df[i][VB-1:0] : '0;
    end
    for (int i = 0; i < NumDiagNb; i++) begin
      dx[i]   = (VB+1)'($signed(fields_i[1+NumAxisNb+i]));
      a_e_d[i] = dx[i] - cx;
    end
    // pp: x+ y+, pm: x+ y-, mp: x- y+, mm: x- y-
    a_t_d[0] = (VB+2)'(nx[0] - cx) + (VB+2)'(nx[2] - cx);
    a_t_d[1] = (VB+2)'(nx[0] - cx) + (VB+2)'(nx[3] - cx);
    a_t_d[2] = (VB+2)'(nx[1] - cx) + (VB+2)'(nx[2] - cx);
    a_t_d[3] = (VB+2)'(nx[1] - cx) + (VB+2)'(nx[3] - cx);
    a_ctrl_d.dil  = dil_i;
    a_ctrl_d.mode = scheme_e'(scheme_i);
    a_ctrl_d.hold = lim_en_i && ((dil_i && (c_s >= up_s)) || (!dil_i && (c_s <= lo_s)));
  end

  // stage b
  logic                 b_vld_q;
  ctrl_t                b_ctrl_q;
  logic [VB-1:0]        b_c_q;
  logic [2*QW-1:0]      b_sq_q [NumAxisNb];
  logic [2*QW-1:0]      b_sq_d [NumAxisNb];
  logic [VB-1:0]        b_max_q, b_max_d;
  logic signed [SW-1:0] b_s_q [NumDiagNb];
  logic signed [SW-1:0] b_s_d [NumDiagNb];
  logic [QW-1:0]        clamped [NumAxisNb];

  always_comb begin
    b_max_d = '0;
    for (int i = 0; i < NumAxisNb; i++) begin
      // rises wider than 31 bits clamp before squaring
      clamped[i] = (VB > QW && (a_rise_q[i] > VB'({QW{1'b1}}))) ? {QW{1'b1}}
                                                              : a_rise_q[i][QW-1:0];
      b_sq_d[i]  = (2*QW)'(clamped[i]) * (2*QW)'(clamped[i]);
      if (a_rise_q[i] > b_max_d) b_max_d = a_rise_q[i];
    end
    for (int i = 0; i < NumDiagNb; i++) begin
      b_s_d[i] = SW'(a_t_q[i]) * $signed(SW'(WSide)) + (SW'(a_e_q[i]) <<< 15);
    end
  end

  // stage c
  logic [N2W-1:0]       n2_d;
  logic [NW-1:0]        alt_d;
  logic signed [SW:0]   rnd [NumDiagNb];
  logic [NW-1:0]        dr  [NumDiagNb];

  always_comb begin
    n2_d  = '0;
    alt_d = NW'(b_max_q);
    for (int i = 0; i < 3; i++) begin
      if (b_ctrl_q.mode == ModeSum) begin
        n2_d = n2_d + N2W'(b_sq_q[2*i]) + N2W'(b_sq_q[2*i+1]);
      end else begin
        n2_d = n2_d + N2W'((b_sq_q[2*i] > b_sq_q[2*i+1]) ? b_sq_q[2*i] : b_sq_q[2*i+1]);
      end
    end
    for (int i = 0; i < NumDiagNb; i++) begin
      rnd[i] = ((SW+1)'(b_s_q[i]) + (SW+1)'(WCorner)) >>> 16;
      dr[i]  = (b_s_q[i] > 0) ? rnd[i][NW-1:0] : '0;
      if (b_ctrl_q.dil && (dr[i] > alt_d)) alt_d = dr[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= valid_i;
      b_vld_q <= a_vld_q;
      valid_o <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_ctrl_q <= a_ctrl_d;
      a_c_q    <= fields_i[0];
      a_rise_q <= a_rise_d;
      a_t_q    <= a_t_d;
      a_e_q    <= a_e_d;
      b_ctrl_q <= a_ctrl_q;
      b_c_q    <= a_c_q;
      b_sq_q   <= b_sq_d;
      b_max_q  <= b_max_d;
      b_s_q    <= b_s_d;
      ctrl_o   <= b_ctrl_q;
      c_o      <= b_c_q;
      n2_o     <= n2_d;
      alt_o    <= alt_d;
    end
  end

endmodule

### design/pmvu_sqrt.sv
// ----------------------------------------------------------------------------
// pmvu_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module pmvu_sqrt #(
  parameter int unsigned VALUE_BITS = pmvu_pkg::DefValueBits
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                en_i,
  input  logic                                                valid_i,
  input  pmvu_pkg::ctrl_t                                     ctrl_i,
  input  logic [VALUE_BITS-1:0]                               c_i,
  input  logic [2*((VALUE_BITS > 31) ? 31 : VALUE_BITS)+2:0]  n2_i,
  input  logic [VALUE_BITS+1:0]                               alt_i,
  output logic                                                valid_o,
  output pmvu_pkg::ctrl_t                                     ctrl_o,
  output logic [VALUE_BITS-1:0]                               c_o,
  output logic [VALUE_BITS+1:0]                               root_o,
  output logic [VALUE_BITS+1:0]                               alt_o
);
  import pmvu_pkg::*;

  localparam int unsigned VB  = VALUE_BITS;
  localparam int unsigned QW  = (VB > 31) ? 31 : VB;
  localparam int unsigned N2W = 2 * QW + 3;
  localparam int unsigned RW  = (N2W + 1) / 2;
  localparam int unsigned NW  = VB + 2;

  logic           vld_q  [RW];
  ctrl_t          ctrl_q [RW];
  logic [VB-1:0]  c_q    [RW];
  logic [NW-1:0]  alt_q  [RW];
  logic [N2W-1:0] rem_q  [RW];
  logic [RW-1:0]  root_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int unsigned Bit = RW - 1 - k;
    localparam logic [N2W+1:0] OneSq = (N2W+2)'(1) << (2 * Bit);

    logic           vld_in;
    ctrl_t          ctrl_in;
    logic [VB-1:0]  c_in;
    logic [NW-1:0]  alt_in;
    logic [N2W-1:0] rem_in;
    logic [RW-1:0]  root_in;
    logic [N2W+1:0] trial;
    logic           take;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign ctrl_in = ctrl_i;
      assign c_in    = c_i;
      assign alt_in  = alt_i;
      assign rem_in  = n2_i;
      assign root_in = '0;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign ctrl_in = ctrl_q[k-1];
      assign c_in    = c_q[k-1];
      assign alt_in  = alt_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // (root + 2^bit)^2 - root^2
    assign trial = ((N2W+2)'(root_in) << (Bit + 1)) + OneSq;
    assign take  = (N2W+2)'(rem_in) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctrl_q[k] <= ctrl_in;
        c_q[k]    <= c_in;
        alt_q[k]  <= alt_in;
        rem_q[k]  <= take ? N2W'((N2W+2)'(rem_in) - trial) : rem_in;
        root_q[k] <= take ? (root_in | (RW'(1) << Bit)) : root_in;
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign ctrl_o  = ctrl_q[RW-1];
  assign c_o     = c_q[RW-1];
  assign alt_o   = alt_q[RW-1];
  assign root_o  = NW'(root_q[RW-1]);

endmodule

### design/pmvu_update.sv
// ----------------------------------------------------------------------------
// pmvu_update
// norm select, times dt, rounding, signed update with saturation
// ----------------------------------------------------------------------------
module pmvu_update #(
  parameter int unsigned VALUE_BITS = pmvu_pkg::DefValueBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  pmvu_pkg::ctrl_t                 ctrl_i,
  input  logic [VALUE_BITS-1:0]           c_i,
  input  logic [VALUE_BITS+1:0]           root_i,
  input  logic [VALUE_BITS+1:0]           alt_i,
  input  logic [pmvu_pkg::DtBits-1:0]     dt_i,
  output logic                            valid_o,
  output logic [VALUE_BITS-1:0]           value_o,
  output logic                            held_o
);
  import pmvu_pkg::*;

  localparam int unsigned VB = VALUE_BITS;
  localparam int unsigned NW = VB + 2;
  localparam int unsigned PW = NW + DtBits;
  localparam int unsigned DW = PW + 1 - DtFracBits;
  localparam int unsigned RW = DW + 2;

  logic          d_vld_q;
  ctrl_t         d_ctrl_q;
  logic [VB-1:0] d_c_q;
  logic [PW-1:0] d_prod_q, d_prod_d;
  logic [NW-1:0] norm;

  always_comb begin
    case (ctrl_i.mode)
      ModeSum, ModeMax: norm = root_i;
      ModeDiff:         norm = alt_i;
      default:          norm = '0;
    endcase
    d_prod_d = PW'(norm) * PW'(dt_i);
  end

  logic [PW:0]          rnd;
  logic [DW-1:0]        delta;
  logic signed [RW-1:0] res;
  logic signed [RW-1:0] vmax, vmin;
  logic [VB-1:0]        value_d;

  always_comb begin
    rnd   = (PW+1)'(d_prod_q) + (PW+1)'(1 << (DtFracBits - 1));
    delta = rnd[PW:DtFracBits];
    vmax  = RW'({1'b0, {(VB-1){1'b1}}});
    vmin  = -vmax - RW'(1);
    res   = d_ctrl_q.dil ? (RW'($signed(d_c_q)) + $signed(RW'(delta)))
                         : (RW'($signed(d_c_q)) - $signed(RW'(delta)));
    if (res > vmax)      value_d = vmax[VB-1:0];
    else if (res < vmin) value_d = vmin[VB-1:0];
    else                 value_d = res[VB-1:0];
    if (d_ctrl_q.hold) value_d = d_c_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      d_vld_q <= valid_i;
      valid_o <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_ctrl_q <= ctrl_i;
      d_c_q    <= c_i;
      d_prod_q <= d_prod_d;
      value_o  <= value_d;
      held_o   <= d_ctrl_q.hold;
    end
  end

endmodule

### design/pde_morphology_voxel_update.sv
// stages: front a, b, c; sqrt, one per root bit; update d; output register
// throughput: one voxel per cycle; the pipeline advances as a whole whenever the
//   output register is empty or being taken, so a stall freezes every stage
// reset: all stage valid bits clear; registers return to sum mode, dilate,
//   dt 1.0, limits off, full-range limits
// ----------------------------------------------------------------------------
// pde_morphology_voxel_update
// one explicit time step of pde dilation or erosion for a single voxel
// ----------------------------------------------------------------------------
module pde_morphology_voxel_update #(
  parameter int unsigned VALUE_BITS = pmvu_pkg::DefValueBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  // request side
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // center, x+, x-, y+, y-, z+, z-, diag pp, pm, mp, mm; zero padded to bytes
  input  logic [((pmvu_pkg::NumInFields*VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // result side
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // new_value; zero padded to bytes
  output logic [((VALUE_BITS+7)/8)*8-1:0] m_axis_tdata,
  // held
  output logic m_axis_tuser,
  // register write port
  input  logic                                  cfg_we_i,
  input  logic [pmvu_pkg::CfgIdxBits-1:0]       cfg_idx_i,
  input  logic [((VALUE_BITS > 16) ? VALUE_BITS : 16)-1:0] cfg_data_i
);
  import pmvu_pkg::*;

  localparam int unsigned VB  = VALUE_BITS;
  localparam int unsigned QW  = (VB > 31) ? 31 : VB;
  localparam int unsigned N2W = 2 * QW + 3;
  localparam int unsigned NW  = VB + 2;
  localparam int unsigned ODW = ((VB + 7) / 8) * 8;

  // configuration registers
  logic [1:0]        scheme_q;
  logic              dir_q;
  logic [DtBits-1:0] dt_q;
  logic              lim_en_q;
  logic [VB-1:0]     lower_q;
  logic [VB-1:0]     upper_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scheme_q <= ModeSum;
      dir_q    <= 1'b1;
      dt_q     <= DtBits'(1 << DtFracBits);
      lim_en_q <= 1'b0;
      lower_q  <= {1'b1, {(VB-1){1'b0}}};
      upper_q  <= {1'b0, {(VB-1){1'b1}}};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegSchemeMode:   scheme_q <= cfg_data_i[1:0];
        RegDirection:    dir_q    <= cfg_data_i[0];
        RegTimeStep:     dt_q     <= cfg_data_i[DtBits-1:0];
        RegLimitsEnable: lim_en_q <= cfg_data_i[0];
        RegLowerLimit:   lower_q  <= cfg_data_i[VB-1:0];
        RegUpperLimit:   upper_q  <= cfg_data_i[VB-1:0];
        default:         ; // unused indexes are ignored
      endcase
    end
  end

  // global advance: the output register is free or drains this cycle
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // unpack the request fields
  logic [NumInFields-1:0][VB-1:0] fields;
  assign fields = s_axis_tdata[NumInFields*VB-1:0];

  // front: rises, squares, diagonal terms, squared norm
  logic           f_vld;
  ctrl_t          f_ctrl;
  logic [VB-1:0]  f_c;
  logic [N2W-1:0] f_n2;
  logic [NW-1:0]  f_alt;

  pmvu_front #(.VALUE_BITS(VB)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .fields_i (fields),
    .scheme_i (scheme_q),
    .dil_i    (dir_q),
    .lim_en_i (lim_en_q),
    .lower_i  (lower_q),
    .upper_i  (upper_q),
    .valid_o  (f_vld),
    .ctrl_o   (f_ctrl),
    .c_o      (f_c),
    .n2_o     (f_n2),
    .alt_o    (f_alt)
  );

  // square root, one bit per stage
  logic          r_vld;
  ctrl_t         r_ctrl;
  logic [VB-1:0] r_c;
  logic [NW-1:0] r_root;
  logic [NW-1:0] r_alt;

  pmvu_sqrt #(.VALUE_BITS(VB)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_vld),
    .ctrl_i  (f_ctrl),
    .c_i     (f_c),
    .n2_i    (f_n2),
    .alt_i   (f_alt),
    .valid_o (r_vld),
    .ctrl_o  (r_ctrl),
    .c_o     (r_c),
    .root_o  (r_root),
    .alt_o   (r_alt)
  );

  // scale by dt, apply, saturate; last stage is the output register
  logic [VB-1:0] new_value;

  pmvu_update #(.VALUE_BITS(VB)) u_update (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r_vld),
    .ctrl_i  (r_ctrl),
    .c_i     (r_c),
    .root_i  (r_root),
    .alt_i   (r_alt),
    .dt_i    (dt_q),
    .valid_o (m_axis_tvalid),
    .value_o (new_value),
    .held_o  (m_axis_tuser)
  );

  assign m_axis_tdata = ODW'(new_value);

endmodule
